/* hw/rtl/glp_pkg.sv */
// ----------------------------------------------------------------------------
// glp_pkg: shared types and constants of the G-code line parser
// Character codes, limits, word phases, status codes and result record.
// ----------------------------------------------------------------------------
package glp_pkg;

	localparam int LINE_MAX   = 128;
	localparam int WORD_MAX   = 16;
	localparam int WORDS_MAX  = 8;

	localparam int BYTE_W     = 8;
	localparam int VAL_W      = 32;
	localparam int LINE_CNT_W = 8;
	localparam int CHAR_CNT_W = 5;
	localparam int WORD_CNT_W = 4;
	localparam int AXIS_N     = 3;
	localparam int AXIS_W     = 2;
	localparam int FRAC_W     = 2;
	localparam int DIGIT_W    = 4;
	localparam int SCALE_W    = 7;
	localparam int CFG_IDX_W  = 1;

	localparam int PE_CMD     = 0;
	localparam int PE_AXIS    = 1;

	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_1     = 8'h31;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
	localparam logic [BYTE_W-1:0] CH_G     = 8'h47;
	localparam logic [BYTE_W-1:0] CH_X     = 8'h58;
	localparam logic [BYTE_W-1:0] CH_Y     = 8'h59;
	localparam logic [BYTE_W-1:0] CH_Z     = 8'h5A;

	localparam logic [VAL_W-1:0] MAG_CAP = 32'h8000_0000;
	localparam logic [VAL_W-1:0] POS_MAX = 32'h7FFF_FFFF;

	localparam logic signed [VAL_W-1:0] MIN_VALUE_RST = -32'sd1000000;
	localparam logic signed [VAL_W-1:0] MAX_VALUE_RST = 32'sd1000000;

	typedef enum logic [2:0] {
		PH_LETTER,
		PH_GNUM,
		PH_CMD_TAIL,
		PH_SIGN,
		PH_INT,
		PH_FRAC,
		PH_VAL_TAIL,
		PH_BAD_WORD
	} phase_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED,
		ST_RANGE,
		ST_BAD_CMD,
		ST_BAD_AXIS,
		ST_LINE_LONG,
		ST_WORD_LONG,
		ST_MANY_WORDS
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_VALUE,
		CFG_MAX_VALUE
	} cfg_reg_t;

	typedef struct packed {
		logic               int_mode;
		logic [DIGIT_W-1:0] digit;
		logic [FRAC_W-1:0]  frac_digits;
	} digit_op_t;

	typedef struct packed {
		status_t                  status;
		logic                     command;
		logic signed [VAL_W-1:0]  x_pos;
		logic signed [VAL_W-1:0]  y_pos;
		logic signed [VAL_W-1:0]  z_pos;
	} result_t;

	function automatic logic [SCALE_W-1:0] frac_scale(input logic [FRAC_W-1:0] idx);
		logic [SCALE_W-1:0] s;
		case (idx)
			2'd0: s = 7'd100;
			2'd1: s = 7'd10;
			default: s = 7'd1;
		endcase
		return s;
	endfunction

endpackage

/* hw/rtl/glp_digit_acc.sv */
// ----------------------------------------------------------------------------
// glp_digit_acc: decimal digit accumulator
// Adds one integer or fraction digit to a thousandths magnitude, saturating.
// ----------------------------------------------------------------------------
module glp_digit_acc (
	input  logic [glp_pkg::VAL_W-1:0] acc,
	input  glp_pkg::digit_op_t        op,
	output logic [glp_pkg::VAL_W-1:0] acc_next
);

	logic [glp_pkg::VAL_W+3:0] int_sum;
	logic [glp_pkg::VAL_W:0]   frac_sum;

	always_comb begin
		int_sum  = {4'b0, acc} * 36'd10 + 36'(op.digit) * 36'd1000;
		frac_sum = {1'b0, acc} + 33'(op.digit) * 33'(glp_pkg::frac_scale(op.frac_digits));
		if (op.int_mode) begin
			acc_next = (int_sum > 36'(glp_pkg::MAG_CAP)) ? glp_pkg::MAG_CAP
				: int_sum[glp_pkg::VAL_W-1:0];
		end else begin
			acc_next = (frac_sum > 33'(glp_pkg::MAG_CAP)) ? glp_pkg::MAG_CAP
				: frac_sum[glp_pkg::VAL_W-1:0];
		end
	end

endmodule

/* hw/rtl/glp_line_fsm.sv */
// ----------------------------------------------------------------------------
// glp_line_fsm: per-byte tokenizer and word parser
// Holds line state, walks word phases and forms one result per line or error.
// ----------------------------------------------------------------------------
module glp_line_fsm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [glp_pkg::BYTE_W-1:0]        line_byte,
	input  logic signed [glp_pkg::VAL_W-1:0]  min_value,
	input  logic signed [glp_pkg::VAL_W-1:0]  max_value,
	output logic                              res_valid,
	output glp_pkg::result_t                  res
);

	logic                                in_word_q;
	logic [glp_pkg::LINE_CNT_W-1:0]      line_count_q;
	logic [glp_pkg::CHAR_CNT_W-1:0]      char_count_q;
	logic [glp_pkg::WORD_CNT_W-1:0]      word_count_q;
	glp_pkg::phase_t                     phase_q;
	logic [glp_pkg::AXIS_W-1:0]          axis_sel_q;
	logic [glp_pkg::VAL_W-1:0]           acc_q;
	logic [glp_pkg::FRAC_W-1:0]          frac_q;
	logic                                neg_q;
	logic                                cmd_q;
	logic [1:0]                          perr_q;
	logic                                drain_q;
	logic signed [glp_pkg::VAL_W-1:0]    axis_q [glp_pkg::AXIS_N];

	logic                                is_zero, is_space, is_digit, is_axis, started;
	logic                                line_full, char_full, words_full;
	logic                                sp_fail, start_fail, ch_fail, line_clr;
	logic [glp_pkg::WORD_CNT_W-1:0]      wc_inc, wc_cur;
	logic [glp_pkg::CHAR_CNT_W-1:0]      char_base;
	glp_pkg::phase_t                     phase_cur, phase_nx;
	logic                                tc_err_cmd, tc_err_axis, tc_axis_load;
	logic                                tc_set_cmd, tc_cmd, tc_set_neg, tc_acc_upd, tc_frac_inc;
	glp_pkg::digit_op_t                  dop;
	logic [glp_pkg::VAL_W-1:0]           acc_next;
	logic                                ew_store, ew_bad_cmd;
	logic signed [glp_pkg::VAL_W-1:0]    ew_val;
	logic signed [glp_pkg::VAL_W-1:0]    axis_ew [glp_pkg::AXIS_N];
	logic [glp_pkg::AXIS_N-1:0]          in_rng;
	logic [1:0]                          perr_end;
	glp_pkg::status_t                    end_status, res_status;
	logic                                full;

	glp_digit_acc u_digit_acc (
		.acc      (acc_q),
		.op       (dop),
		.acc_next (acc_next)
	);

	always_comb begin
		is_zero    = (line_byte == glp_pkg::CH_NUL);
		is_space   = (line_byte == glp_pkg::CH_SPACE);
		is_digit   = (line_byte >= glp_pkg::CH_0) && (line_byte <= glp_pkg::CH_9);
		is_axis    = (line_byte == glp_pkg::CH_X) || (line_byte == glp_pkg::CH_Y)
			|| (line_byte == glp_pkg::CH_Z);
		started    = !in_word_q;
		wc_inc     = word_count_q + glp_pkg::WORD_CNT_W'(1);
		wc_cur     = started ? wc_inc : word_count_q;
		phase_cur  = started ? glp_pkg::PH_LETTER : phase_q;
		char_base  = started ? '0 : char_count_q;
		line_full  = line_count_q >= glp_pkg::LINE_CNT_W'(glp_pkg::LINE_MAX);
		char_full  = !started && (char_count_q >= glp_pkg::CHAR_CNT_W'(glp_pkg::WORD_MAX));
		words_full = word_count_q >= glp_pkg::WORD_CNT_W'(glp_pkg::WORDS_MAX);
		sp_fail    = is_space && line_full;
		start_fail = !is_zero && !is_space && started && words_full;
		ch_fail    = !is_zero && !is_space && !start_fail && (char_full || line_full);
		line_clr   = accept && is_zero;
	end

	// next word phase
	always_comb begin
		phase_nx = phase_cur;
		case (phase_cur)
			glp_pkg::PH_LETTER: begin
				if (wc_cur == glp_pkg::WORD_CNT_W'(1)) begin
					phase_nx = (line_byte == glp_pkg::CH_G) ? glp_pkg::PH_GNUM
						: glp_pkg::PH_CMD_TAIL;
				end else begin
					phase_nx = is_axis ? glp_pkg::PH_SIGN : glp_pkg::PH_BAD_WORD;
				end
			end
			glp_pkg::PH_GNUM: phase_nx = glp_pkg::PH_CMD_TAIL;
			glp_pkg::PH_SIGN: begin
				if (line_byte == glp_pkg::CH_PLUS || line_byte == glp_pkg::CH_MINUS || is_digit)
					phase_nx = glp_pkg::PH_INT;
				else if (line_byte == glp_pkg::CH_DOT)
					phase_nx = glp_pkg::PH_FRAC;
				else
					phase_nx = glp_pkg::PH_VAL_TAIL;
			end
			glp_pkg::PH_INT: begin
				if (is_digit)
					phase_nx = glp_pkg::PH_INT;
				else if (line_byte == glp_pkg::CH_DOT)
					phase_nx = glp_pkg::PH_FRAC;
				else
					phase_nx = glp_pkg::PH_VAL_TAIL;
			end
			glp_pkg::PH_FRAC: begin
				if (!is_digit)
					phase_nx = glp_pkg::PH_VAL_TAIL;
			end
			default: phase_nx = phase_cur;
		endcase
	end

	// per-phase actions
	always_comb begin
		tc_err_cmd   = 1'b0;
		tc_err_axis  = 1'b0;
		tc_axis_load = 1'b0;
		tc_set_cmd   = 1'b0;
		tc_cmd       = 1'b0;
		tc_set_neg   = 1'b0;
		tc_acc_upd   = 1'b0;
		tc_frac_inc  = 1'b0;
		dop.int_mode    = (phase_cur != glp_pkg::PH_FRAC);
		dop.digit       = line_byte[glp_pkg::DIGIT_W-1:0];
		dop.frac_digits = frac_q;
		case (phase_cur)
			glp_pkg::PH_LETTER: begin
				if (wc_cur == glp_pkg::WORD_CNT_W'(1))
					tc_err_cmd = (line_byte != glp_pkg::CH_G);
				else if (is_axis)
					tc_axis_load = 1'b1;
				else
					tc_err_axis = 1'b1;
			end
			glp_pkg::PH_GNUM: begin
				if (line_byte == glp_pkg::CH_0) begin
					tc_set_cmd = 1'b1;
				end else if (line_byte == glp_pkg::CH_1) begin
					tc_set_cmd = 1'b1;
					tc_cmd     = 1'b1;
				end else begin
					tc_err_cmd = 1'b1;
				end
			end
			glp_pkg::PH_SIGN: begin
				tc_set_neg = (line_byte == glp_pkg::CH_PLUS) || (line_byte == glp_pkg::CH_MINUS);
				tc_acc_upd = is_digit;
			end
			glp_pkg::PH_INT: tc_acc_upd = is_digit;
			glp_pkg::PH_FRAC: begin
				tc_acc_upd  = is_digit && (frac_q != 2'd3);
				tc_frac_inc = tc_acc_upd;
			end
			default: ;
		endcase
	end

	// word close and line result
	always_comb begin
		ew_store   = in_word_q && (phase_q == glp_pkg::PH_SIGN || phase_q == glp_pkg::PH_INT
			|| phase_q == glp_pkg::PH_FRAC || phase_q == glp_pkg::PH_VAL_TAIL);
		ew_bad_cmd = in_word_q && (phase_q == glp_pkg::PH_GNUM);
		if (neg_q)
			ew_val = glp_pkg::VAL_W'('0 - acc_q);
		else
			ew_val = (acc_q > glp_pkg::POS_MAX) ? glp_pkg::POS_MAX : acc_q;
		for (int i = 0; i < glp_pkg::AXIS_N; i++) begin
			axis_ew[i] = (ew_store && axis_sel_q == glp_pkg::AXIS_W'(i)) ? ew_val : axis_q[i];
			in_rng[i]  = (axis_ew[i] > min_value) && (axis_ew[i] < max_value);
		end
		perr_end = perr_q | {1'b0, ew_bad_cmd};
		if (perr_end[glp_pkg::PE_CMD] || word_count_q == '0)
			end_status = glp_pkg::ST_BAD_CMD;
		else if (perr_end[glp_pkg::PE_AXIS])
			end_status = glp_pkg::ST_BAD_AXIS;
		else if (&in_rng)
			end_status = glp_pkg::ST_ACCEPTED;
		else
			end_status = glp_pkg::ST_RANGE;

		if (is_zero)
			res_status = end_status;
		else if (sp_fail)
			res_status = glp_pkg::ST_LINE_LONG;
		else if (start_fail)
			res_status = glp_pkg::ST_MANY_WORDS;
		else if (char_full)
			res_status = glp_pkg::ST_WORD_LONG;
		else
			res_status = glp_pkg::ST_LINE_LONG;

		full = is_zero && (end_status == glp_pkg::ST_ACCEPTED
			|| end_status == glp_pkg::ST_RANGE);
		res_valid   = accept && !drain_q && (is_zero || sp_fail || start_fail || ch_fail);
		res.status  = res_status;
		res.command = full ? cmd_q : 1'b0;
		res.x_pos   = full ? axis_ew[0] : '0;
		res.y_pos   = full ? axis_ew[1] : '0;
		res.z_pos   = full ? axis_ew[2] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q    <= 1'b0;
			line_count_q <= '0;
			char_count_q <= '0;
			word_count_q <= '0;
			phase_q      <= glp_pkg::PH_LETTER;
			axis_sel_q   <= '0;
			acc_q        <= '0;
			frac_q       <= '0;
			neg_q        <= 1'b0;
			cmd_q        <= 1'b0;
			perr_q       <= '0;
			drain_q      <= 1'b0;
			for (int i = 0; i < glp_pkg::AXIS_N; i++)
				axis_q[i] <= '0;
		end else if (line_clr) begin
			in_word_q    <= 1'b0;
			line_count_q <= '0;
			char_count_q <= '0;
			word_count_q <= '0;
			phase_q      <= glp_pkg::PH_LETTER;
			axis_sel_q   <= '0;
			acc_q        <= '0;
			frac_q       <= '0;
			neg_q        <= 1'b0;
			cmd_q        <= 1'b0;
			perr_q       <= '0;
			drain_q      <= 1'b0;
			for (int i = 0; i < glp_pkg::AXIS_N; i++)
				axis_q[i] <= '0;
		end else if (accept && !drain_q) begin
			if (is_space) begin
				if (in_word_q) begin
					for (int i = 0; i < glp_pkg::AXIS_N; i++)
						axis_q[i] <= axis_ew[i];
					perr_q    <= perr_end;
					in_word_q <= 1'b0;
				end
				if (line_full)
					drain_q <= 1'b1;
				else
					line_count_q <= line_count_q + glp_pkg::LINE_CNT_W'(1);
			end else if (start_fail || ch_fail) begin
				drain_q <= 1'b1;
			end else begin
				if (started) begin
					word_count_q <= wc_inc;
					in_word_q    <= 1'b1;
				end
				line_count_q <= line_count_q + glp_pkg::LINE_CNT_W'(1);
				char_count_q <= char_base + glp_pkg::CHAR_CNT_W'(1);
				phase_q      <= phase_nx;
				if (tc_err_cmd)
					perr_q[glp_pkg::PE_CMD] <= 1'b1;
				if (tc_err_axis)
					perr_q[glp_pkg::PE_AXIS] <= 1'b1;
				if (tc_axis_load) begin
					axis_sel_q <= line_byte[glp_pkg::AXIS_W-1:0];
					acc_q      <= '0;
					frac_q     <= '0;
					neg_q      <= 1'b0;
				end
				if (tc_set_cmd)
					cmd_q <= tc_cmd;
				if (tc_set_neg)
					neg_q <= (line_byte == glp_pkg::CH_MINUS);
				if (tc_acc_upd)
					acc_q <= acc_next;
				if (tc_frac_inc)
					frac_q <= frac_q + glp_pkg::FRAC_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/gcode_line_parser_core.sv */
// ----------------------------------------------------------------------------
// gcode_line_parser_core: G0/G1 XYZ line parser
// Parses one byte per cycle while in_stall is low and emits one status record per line or error.
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------------------
//  input     | in_valid / in_stall     | line_byte
//  result    | out_valid / out_stall   | status, command, x_pos, y_pos, z_pos
//  config    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  One byte per cycle while in_stall is low; parser state updates in the cycle a byte is taken.
//  A result is registered into out_q, or into the skid entry while out_q holds a stalled result.
//  A two-entry output register pair absorbs a stalled result; in_stall rises
//  only while both entries are full.
//  Reset restores the bounds to -1000000 and 1000000 and clears all state but the result data registers.
// ----------------------------------------------------------------------------
module gcode_line_parser_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [glp_pkg::BYTE_W-1:0]            line_byte,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [2:0]                            status,
	output logic                                  command,
	output logic signed [glp_pkg::VAL_W-1:0]      x_pos,
	output logic signed [glp_pkg::VAL_W-1:0]      y_pos,
	output logic signed [glp_pkg::VAL_W-1:0]      z_pos,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [glp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [glp_pkg::VAL_W-1:0]             cfg_data
);

	logic signed [glp_pkg::VAL_W-1:0] min_value_q, max_value_q;
	logic                             accept, res_valid, take;
	glp_pkg::result_t                 res;
	logic                             out_valid_q, skid_valid_q;
	glp_pkg::result_t                 out_q, skid_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign accept    = in_valid && !in_stall;
	assign take      = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_value_q <= glp_pkg::MIN_VALUE_RST;
			max_value_q <= glp_pkg::MAX_VALUE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (glp_pkg::cfg_reg_t'(cfg_index))
				glp_pkg::CFG_MIN_VALUE: min_value_q <= cfg_data;
				glp_pkg::CFG_MAX_VALUE: max_value_q <= cfg_data;
				default: ;
			endcase
		end
	end

	glp_line_fsm u_line_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.line_byte (line_byte),
		.min_value (min_value_q),
		.max_value (max_value_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			out_valid_q  <= skid_valid_q || res_valid;
			skid_valid_q <= skid_valid_q && res_valid;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (res_valid)
					skid_q <= res;
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign command   = out_q.command;
	assign x_pos     = out_q.x_pos;
	assign y_pos     = out_q.y_pos;
	assign z_pos     = out_q.z_pos;

endmodule

/* hw/rtl/glp_checker.sv */
// ----------------------------------------------------------------------------
// glp_checker: port-level checks for the G-code line parser
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module glp_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_stall,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic [2:0]                            status,
	input  logic                                  command,
	input  logic signed [glp_pkg::VAL_W-1:0]      x_pos,
	input  logic signed [glp_pkg::VAL_W-1:0]      y_pos,
	input  logic signed [glp_pkg::VAL_W-1:0]      z_pos
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result transaction dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(command)
			&& $stable(x_pos) && $stable(y_pos) && $stable(z_pos))
		else $error("stalled result transaction changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != glp_pkg::ST_ACCEPTED && status != glp_pkg::ST_RANGE
			|-> command == 1'b0 && x_pos == '0 && y_pos == '0 && z_pos == '0)
		else $error("error result carries nonzero fields");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty result register");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall raised without a blocked result");

endmodule

bind gcode_line_parser_core glp_checker u_glp_checker (.*);
